@@ sv/mmcs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the min-max contrast stretch core.
package mmcs_pkg;

    // Pixel width and the number of quotient bits produced by the divider.
    localparam int PIX_W     = 8;
    localparam int DIV_STEPS = PIX_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [PIX_W-1:0] FULL_SCALE = 8'd255;
    localparam logic [PIX_W-1:0] PIX_ZERO   = 8'd0;

    // Beat kinds carried in tuser.
    localparam logic CMD_MEASURE   = 1'b0;
    localparam logic CMD_NORMALIZE = 1'b1;

    // Controller states, one-hot.
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DIVIDE = 3'b010,
        ST_WAIT   = 3'b100
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic measure;     // fold the input pixel into the marks
        logic start;       // capture a normalize beat and set up the divider
        logic step;        // run one restoring division step
        logic load_step;   // load the output register from the final step
        logic load_held;   // load the output register from the held quotient
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;    // output register is empty or drains this cycle
    } dp_status_t;

endpackage

@@ sv/min_max_contrast_stretch_core.sv @@
`timescale 1ns / 1ps
// A normalize beat is captured, run through the 8-step bit-serial divider and then loaded into the output register.
// The input closes while a normalize beat is divided or waits for the output register, so the next beat waits for it.
// Measure beats are taken every cycle while the divider is idle and give no output beat.
// A finished result waits in the output register while the next beat is accepted.
// Reset (rst_n low, asynchronous) sets the marks to 255 and 0 and empties the output.
// Top level of the min-max contrast stretch core.
module min_max_contrast_stretch_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [mmcs_pkg::PIX_W-1:0]    s_axis_tdata,   // [7:0] pixel
    input  logic                          s_axis_tuser,   // [0] command
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [mmcs_pkg::PIX_W-1:0]    m_axis_tdata,   // [7:0] stretched
    output logic                          m_axis_tlast
);
    import mmcs_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Sequencer.
    mmcs_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    // Marks, divider and output stage.
    mmcs_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .pixel         (s_axis_tdata),
        .last          (s_axis_tlast),
        .cmd           (cmd),
        .status        (status),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

@@ sv/mmcs_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine that sequences measure beats and the bit-serial divide.
module mmcs_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tuser,
    output logic                   s_axis_tready,
    input  mmcs_pkg::dp_status_t   status,
    output mmcs_pkg::ctrl_cmd_t    cmd
);
    import mmcs_pkg::*;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             accept;
    logic             last_step;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign last_step     = (count_reg == CNT_W'(DIV_STEPS - 1));

    // Next state and commands.
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (s_axis_tuser == CMD_MEASURE))
                begin
                    cmd.measure = 1'b1;
                end
                else if (accept)
                begin
                    cmd.start  = 1'b1;
                    count_next = '0;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.step   = 1'b1;
                count_next = count_reg + CNT_W'(1);
                if (last_step)
                begin
                    if (status.out_free)
                    begin
                        cmd.load_step = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_WAIT;
                    end
                end
            end
            ST_WAIT:
            begin
                if (status.out_free)
                begin
                    cmd.load_held = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

endmodule

@@ sv/mmcs_datapath.sv @@
`timescale 1ns / 1ps
// Datapath: min and max marks, restoring divider and output register.
module mmcs_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [mmcs_pkg::PIX_W-1:0]    pixel,
    input  logic                          last,
    input  mmcs_pkg::ctrl_cmd_t           cmd,
    output mmcs_pkg::dp_status_t          status,
    input  logic                          m_axis_tready,
    output logic                          m_axis_tvalid,
    output logic [mmcs_pkg::PIX_W-1:0]    m_axis_tdata,
    output logic                          m_axis_tlast
);
    import mmcs_pkg::*;

    logic [PIX_W-1:0]   low_mark_reg;
    logic [PIX_W-1:0]   high_mark_reg;
    logic               frame_open_reg;
    logic [PIX_W-1:0]   base_low;
    logic [PIX_W-1:0]   base_high;

    logic [PIX_W-1:0]   span_reg;
    logic [PIX_W-1:0]   rem_reg;
    logic [PIX_W-1:0]   shift_reg;
    logic [PIX_W-1:0]   quot_reg;
    logic               zero_reg;
    logic               full_reg;
    logic               last_reg;

    logic [PIX_W-1:0]   offset;
    logic [2*PIX_W-1:0] dividend;
    logic [PIX_W:0]     trial;
    logic               q_bit;
    logic [PIX_W-1:0]   rem_step;
    logic [PIX_W-1:0]   quot_step;
    logic [PIX_W-1:0]   result;

    logic               out_valid_reg;
    logic [PIX_W-1:0]   out_data_reg;
    logic               out_last_reg;
    logic               load;

    // Marks restart from 255 and 0 when no measure pass is open.
    assign base_low  = frame_open_reg ? low_mark_reg  : FULL_SCALE;
    assign base_high = frame_open_reg ? high_mark_reg : PIX_ZERO;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_mark_reg   <= FULL_SCALE;
            high_mark_reg  <= PIX_ZERO;
            frame_open_reg <= 1'b0;
        end
        else if (cmd.measure)
        begin
            low_mark_reg   <= (pixel < base_low)  ? pixel : base_low;
            high_mark_reg  <= (pixel > base_high) ? pixel : base_high;
            frame_open_reg <= !last;
        end
    end

    // Dividend is (pixel - low) * 255, formed as a shift and a subtract.
    assign offset   = pixel - low_mark_reg;
    assign dividend = {offset, PIX_ZERO} - {PIX_ZERO, offset};

    // One restoring step: bring down a dividend bit and try the subtract.
    assign trial     = {rem_reg, shift_reg[PIX_W-1]};
    assign q_bit     = (trial >= {1'b0, span_reg});
    assign rem_step  = q_bit ? PIX_W'(trial - {1'b0, span_reg}) : trial[PIX_W-1:0];
    assign quot_step = {quot_reg[PIX_W-2:0], q_bit};

    // Divider registers; the quotient fits whenever it is used, since for a pixel inside
    // the marks the dividend's top half is below the span.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            span_reg  <= high_mark_reg - low_mark_reg;
            rem_reg   <= dividend[2*PIX_W-1:PIX_W];
            shift_reg <= dividend[PIX_W-1:0];
            quot_reg  <= PIX_ZERO;
            zero_reg  <= (high_mark_reg <= low_mark_reg) || (pixel <= low_mark_reg);
            full_reg  <= (pixel >= high_mark_reg);
            last_reg  <= last;
        end
        else if (cmd.step)
        begin
            rem_reg   <= rem_step;
            shift_reg <= {shift_reg[PIX_W-2:0], 1'b0};
            quot_reg  <= quot_step;
        end
    end

    // Flat range and pixels at or outside the marks bypass the quotient.
    always_comb
    begin
        priority if (zero_reg)
        begin
            result = PIX_ZERO;
        end
        else if (full_reg)
        begin
            result = FULL_SCALE;
        end
        else if (cmd.load_step)
        begin
            result = quot_step;
        end
        else
        begin
            result = quot_reg;
        end
    end

    // Output register decouples the divider from the downstream stall.
    assign load            = cmd.load_step || cmd.load_held;
    assign status.out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= result;
            out_last_reg <= last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

@@ sv/mmcs_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the contrast stretch core, with its bind.
module mmcs_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          s_axis_tuser,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [mmcs_pkg::PIX_W-1:0]    m_axis_tdata,
    input logic                          m_axis_tlast
);
    import mmcs_pkg::*;

    // A stalled output beat holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    // A normalize beat occupies the divider, so the input closes next cycle.
    a_norm_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_NORMALIZE) |=>
            !s_axis_tready)
        else $error("input ready while divider busy");

    // A measure beat never blocks the input.
    a_meas_open: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_MEASURE) |=>
            s_axis_tready)
        else $error("input stalled after measure beat");

    // The result of a normalize beat is presented after the divide completes.
    a_norm_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_NORMALIZE) |->
            ##9 m_axis_tvalid)
        else $error("normalize beat produced no output");

endmodule

bind min_max_contrast_stretch_core mmcs_checker u_mmcs_checker (.*);

@@ test/min_max_contrast_stretch_core_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the min-max contrast stretch core with a behavioral predictor.
module min_max_contrast_stretch_core_test;

    import mmcs_pkg::*;

    localparam int RANDOM_BEATS = 1100;
    localparam int QUIET_AFTER  = 950;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 20;

    // One pixel beat waiting for the driver, or a marker that makes it hold off.
    typedef struct {
        logic             cmd;
        logic [PIX_W-1:0] pix;
        logic             last;
        bit               drain;
        bit               quiet;
    } pixel_beat_t;

    // One stretched beat as the master side should present it.
    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic             last;
    } stretched_beat_t;

    logic             clk           = 1'b0;
    logic             rst_n         = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [PIX_W-1:0] s_axis_tdata  = '0;   // [7:0] pixel
    logic             s_axis_tuser  = CMD_MEASURE;   // [0] command
    logic             s_axis_tlast  = 1'b0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [PIX_W-1:0] m_axis_tdata;   // [7:0] stretched
    logic             m_axis_tlast;

    pixel_beat_t     pixel_beats[$];
    stretched_beat_t stretched_due[$];

    // Predictor state: the running marks and whether a measure pass is open.
    logic [PIX_W-1:0] seen_min  = FULL_SCALE;
    logic [PIX_W-1:0] seen_max  = PIX_ZERO;
    logic             pass_open = 1'b0;

    logic in_fire    = 1'b0;
    bit   quiet_tail = 1'b0;
    bit   failed     = 1'b0;
    int   send_hold  = 0;
    int   sink_hold  = 0;
    int   cycles     = 0;
    int   beats_queued = 0;

    min_max_contrast_stretch_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #4 clk = ~clk;

    // Stretch one pixel over the measured range with an exact integer quotient.
    function automatic logic [PIX_W-1:0] stretch_value(logic [PIX_W-1:0] p,
                                                       logic [PIX_W-1:0] lo,
                                                       logic [PIX_W-1:0] hi);
        int unsigned scaled;
        if (hi <= lo || p <= lo)
            return PIX_ZERO;
        if (p >= hi)
            return FULL_SCALE;
        scaled = (int'(p) - int'(lo)) * int'(FULL_SCALE);
        return PIX_W'(scaled / (int'(hi) - int'(lo)));
    endfunction

    task automatic queue_beat(logic cmd, logic [PIX_W-1:0] pix, logic last);
        pixel_beat_t b;
        b.cmd   = cmd;
        b.pix   = pix;
        b.last  = last;
        b.drain = 1'b0;
        b.quiet = (beats_queued >= QUIET_AFTER);
        pixel_beats.push_back(b);
        beats_queued++;
    endtask

    task automatic queue_drain();
        pixel_beat_t b;
        b.cmd   = CMD_MEASURE;
        b.pix   = '0;
        b.last  = 1'b0;
        b.drain = 1'b1;
        b.quiet = (beats_queued >= QUIET_AFTER);
        pixel_beats.push_back(b);
    endtask

    // One frame: a measure pass over random pixels, then a normalize pass over pixels drawn from the frame,
    // its base value and random values; a broken frame adds stray normalize beats and random last flags.
    task automatic queue_frame();
        logic [PIX_W-1:0] frame[16];
        logic [PIX_W-1:0] base;
        logic [PIX_W-1:0] pick;
        int               len;
        int               frame_len;
        int               spread;
        int               value;
        bit               broken;
        logic             last;
        len    = $urandom_range(1, 16);
        base   = PIX_W'($urandom_range(0, 255));
        broken = ($urandom_range(0, 9) == 0);
        case ($urandom_range(0, 3))
            0: spread = $urandom_range(0, 3);
            1: spread = $urandom_range(0, 40);
            default: spread = 255;
        endcase
        for (int i = 0; i < len; i++)
        begin
            value = int'(base) + $urandom_range(0, spread);
            frame[i] = (value > 255) ? FULL_SCALE : PIX_W'(value);
            last = (i == len - 1);
            if (broken)
            begin
                last = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 3) == 0)
                    queue_beat(CMD_NORMALIZE, PIX_W'($urandom),
                               1'($urandom_range(0, 1)));
            end
            queue_beat(CMD_MEASURE, frame[i], last);
        end
        frame_len = len;
        len = $urandom_range(1, 16);
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 5))
                0: pick = PIX_W'($urandom);
                1: pick = base;
                default: pick = frame[$urandom_range(0, frame_len - 1)];
            endcase
            last = broken ? logic'($urandom_range(0, 1)) : logic'(i == len - 1);
            queue_beat(CMD_NORMALIZE, pick, last);
        end
    endtask

    // Source side: present queued beats, with random bursts of idle cycles.
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || in_fire))
        begin
            if (pixel_beats.size() > 0 && pixel_beats[0].drain)
            begin
                if (stretched_due.size() == 0)
                    void'(pixel_beats.pop_front());
                s_axis_tvalid <= 1'b0;
            end
            else if (send_hold > 0)
            begin
                send_hold     <= send_hold - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 4) == 0)
            begin
                send_hold     <= $urandom_range(0, 4);
                s_axis_tvalid <= 1'b0;
            end
            else if (pixel_beats.size() > 0)
            begin
                s_axis_tuser  <= pixel_beats[0].cmd;
                s_axis_tdata  <= pixel_beats[0].pix;
                s_axis_tlast  <= pixel_beats[0].last;
                s_axis_tvalid <= 1'b1;
                if (pixel_beats[0].quiet)
                    quiet_tail <= 1'b1;
                void'(pixel_beats.pop_front());
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Sink side: stall in random bursts, never in the quiet tail.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (quiet_tail)
            m_axis_tready <= 1'b1;
        else if (sink_hold > 0)
        begin
            sink_hold     <= sink_hold - 1;
            m_axis_tready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            sink_hold     <= $urandom_range(0, 4);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Monitor: check output beats, then run accepted input beats through the predictor.
    always @(posedge clk)
    begin
        stretched_beat_t want;
        cycles  <= cycles + 1;
        in_fire <= s_axis_tvalid && s_axis_tready;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (stretched_due.size() == 0)
            begin
                $display("%0t: unexpected output beat, actual stretched %0d last %0b",
                         $time, m_axis_tdata, m_axis_tlast);
                failed = 1'b1;
            end
            else
            begin
                want = stretched_due.pop_front();
                if (m_axis_tdata !== want.value)
                begin
                    $display("%0t: stretched mismatch, expected %0d actual %0d",
                             $time, want.value, m_axis_tdata);
                    failed = 1'b1;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $display("%0t: last mismatch, expected %0b actual %0b",
                             $time, want.last, m_axis_tlast);
                    failed = 1'b1;
                end
            end
        end
        if (s_axis_tvalid && s_axis_tready)
        begin
            if (s_axis_tuser == CMD_MEASURE)
            begin
                if (!pass_open)
                begin
                    seen_min = FULL_SCALE;
                    seen_max = PIX_ZERO;
                end
                if (s_axis_tdata < seen_min)
                    seen_min = s_axis_tdata;
                if (s_axis_tdata > seen_max)
                    seen_max = s_axis_tdata;
                pass_open = !s_axis_tlast;
            end
            else
            begin
                want.value = stretch_value(s_axis_tdata, seen_min, seen_max);
                want.last  = s_axis_tlast;
                stretched_due.push_back(want);
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial
    begin
        // Empty range right after reset.
        queue_beat(CMD_NORMALIZE, 8'd0, 1'b0);
        queue_beat(CMD_NORMALIZE, 8'd255, 1'b1);
        // Flat frame.
        queue_beat(CMD_MEASURE, 8'd100, 1'b0);
        queue_beat(CMD_MEASURE, 8'd100, 1'b1);
        queue_beat(CMD_NORMALIZE, 8'd99, 1'b0);
        queue_beat(CMD_NORMALIZE, 8'd101, 1'b1);
        // Full range.
        queue_beat(CMD_MEASURE, 8'd0, 1'b0);
        queue_beat(CMD_MEASURE, 8'd255, 1'b1);
        queue_beat(CMD_NORMALIZE, 8'd0, 1'b0);
        queue_beat(CMD_NORMALIZE, 8'd255, 1'b0);
        queue_beat(CMD_NORMALIZE, 8'd128, 1'b0);
        queue_beat(CMD_NORMALIZE, 8'd1, 1'b1);
        // Pixels below the minimum and above the maximum.
        queue_beat(CMD_MEASURE, 8'd50, 1'b0);
        queue_beat(CMD_MEASURE, 8'd200, 1'b0);
        queue_beat(CMD_MEASURE, 8'd120, 1'b1);
        queue_beat(CMD_NORMALIZE, 8'd10, 1'b0);
        queue_beat(CMD_NORMALIZE, 8'd250, 1'b0);
        queue_beat(CMD_NORMALIZE, 8'd51, 1'b0);
        queue_beat(CMD_NORMALIZE, 8'd199, 1'b1);
        // Normalize while a measure pass is still open, then the pass goes on.
        queue_beat(CMD_MEASURE, 8'd30, 1'b0);
        queue_beat(CMD_MEASURE, 8'd60, 1'b0);
        queue_beat(CMD_NORMALIZE, 8'd45, 1'b0);
        queue_beat(CMD_MEASURE, 8'd10, 1'b1);
        queue_beat(CMD_NORMALIZE, 8'd45, 1'b1);
        // Single-pixel frame.
        queue_beat(CMD_MEASURE, 8'd77, 1'b1);
        queue_beat(CMD_NORMALIZE, 8'd77, 1'b1);
        queue_drain();

        begin
            bit drained_mid;
            drained_mid = 1'b0;
            while (beats_queued < RANDOM_BEATS)
            begin
                queue_frame();
                if (!drained_mid && beats_queued > RANDOM_BEATS / 2)
                begin
                    queue_drain();
                    drained_mid = 1'b1;
                end
            end
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pixel_beats.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        while (stretched_due.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (!failed)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
